FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, suspended during reset
`define CHECK_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, also active during reset
`define CHECK_PROP_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/jbee_pkg.sv
// package with widths and huffman code tables for the block entropy encoder
`default_nettype none
package jbee_pkg;

  localparam int COEF_W = 12;
  localparam int POS_W  = 6;
  localparam int SEG_W  = 27;
  localparam int LEN_W  = 5;
  localparam int RUN_W  = 6;
  localparam int CODE_W = 16;
  localparam int BLOCK_COEFFS_DEF = 64;

  localparam logic [7:0] ZRL_SYM = 8'hF0;
  localparam logic [7:0] EOB_SYM = 8'h00;
  localparam logic [5:0] RUN_MAX = 6'd63;

  typedef logic [7:0] cnt_t [16];
  typedef logic [7:0] sym_t [162];
  typedef logic [LEN_W+CODE_W-1:0] rom_t [256];

  localparam cnt_t DC_COUNTS_L = '{8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
                                   8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam cnt_t DC_COUNTS_C = '{8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
                                   8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam cnt_t AC_COUNTS_L = '{8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
                                   8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7D};
  localparam cnt_t AC_COUNTS_C = '{8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3, 8'd4,
                                   8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77};

  localparam sym_t AC_SYMS_L = '{
    8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
    8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'hA1,8'h08,8'h23,8'h42,8'hB1,8'hC1,
    8'h15,8'h52,8'hD1,8'hF0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0A,8'h16,8'h17,8'h18,
    8'h19,8'h1A,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
    8'h3A,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5A,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,8'h75,
    8'h76,8'h77,8'h78,8'h79,8'h7A,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8A,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,
    8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBA,8'hC2,8'hC3,
    8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,
    8'hD9,8'hDA,8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hF1,8'hF2,
    8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA};

  localparam sym_t AC_SYMS_C = '{
    8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
    8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'hA1,8'hB1,8'hC1,8'h09,
    8'h23,8'h33,8'h52,8'hF0,8'h15,8'h62,8'h72,8'hD1,8'h0A,8'h16,8'h24,8'h34,8'hE1,8'h25,
    8'hF1,8'h17,8'h18,8'h19,8'h1A,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h35,8'h36,8'h37,8'h38,
    8'h39,8'h3A,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h53,8'h54,8'h55,8'h56,
    8'h57,8'h58,8'h59,8'h5A,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,
    8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
    8'h8A,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,8'hA4,8'hA5,
    8'hA6,8'hA7,8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBA,
    8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
    8'hD7,8'hD8,8'hD9,8'hDA,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hF2,
    8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA};

  // canonical code assignment, entry is {length, code}
  function automatic rom_t build_rom(cnt_t counts, sym_t syms, logic is_dc);
    rom_t rom;
    logic [CODE_W:0] c;
    int p;
    int nsyms;
    int s;
    rom = '{default: '0};
    c = '0;
    p = 0;
    nsyms = is_dc ? 12 : 162;
    for (int l = 1; l <= 16; l++) begin
      for (int k = 0; k < int'(counts[l-1]); k++) begin
        if (p < nsyms) begin
          s = is_dc ? p : int'(syms[p]);
          rom[s] = {LEN_W'(l), c[CODE_W-1:0]};
        end
        p++;
        c = c + 1'b1;
      end
      c = c << 1;
    end
    return rom;
  endfunction

  localparam rom_t DC_ROM_L = build_rom(DC_COUNTS_L, AC_SYMS_L, 1'b1);
  localparam rom_t DC_ROM_C = build_rom(DC_COUNTS_C, AC_SYMS_C, 1'b1);
  localparam rom_t AC_ROM_L = build_rom(AC_COUNTS_L, AC_SYMS_L, 1'b0);
  localparam rom_t AC_ROM_C = build_rom(AC_COUNTS_C, AC_SYMS_C, 1'b0);

  // bit length of a magnitude up to 11 bits
  function automatic logic [3:0] category(logic [10:0] m);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 11; i++) begin
      if (m[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: design/jpeg_block_entropy_encoder.sv
// block entropy encoder: run/category huffman coding of one coefficient per item
// an accepted item is registered in the input stage, then written into the output queue
// throughput: one item per cycle while in_stall is low; an item with pending runs of 16
// zeros first emits one zrl segment per run (up to 3), absorbed by a 4-entry queue
// the zero-run count lives in a one-entry memory read at accept, written back in the
// following cycle with forwarding; rst clears control state and the run count reads zero
`default_nettype none
module jpeg_block_entropy_encoder #(
  parameter int BLOCK_COEFFS = jbee_pkg::BLOCK_COEFFS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic                                cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [jbee_pkg::COEF_W-1:0]  coefficient,
  input  wire logic        [jbee_pkg::POS_W-1:0]   position,
  input  wire logic signed [jbee_pkg::COEF_W-1:0]  dc_predictor,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic             [jbee_pkg::SEG_W-1:0]   segment_value,
  output logic             [jbee_pkg::LEN_W-1:0]   segment_length,
  output logic                                     last_of_run
);
  import jbee_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_COEFFS - 1);

  logic table_select;

  logic [RUN_W-1:0] zr_mem [1];
  logic             mem_ok;
  logic [RUN_W-1:0] rd_q;
  logic [RUN_W-1:0] wb_q;
  logic             a_fwd;

  logic                     a_valid;
  logic signed [COEF_W-1:0] a_coef;
  logic        [POS_W-1:0]  a_pos;
  logic signed [COEF_W-1:0] a_pred;

  logic [SEG_W-1:0] ent_seg [DEPTH];
  logic [LEN_W-1:0] ent_len [DEPTH];
  logic [1:0]       ent_nz  [DEPTH];
  logic             ent_tsel [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;
  logic [1:0]       zrl_idx;

  logic in_acc;
  logic out_acc;
  logic push;
  logic pop;

  logic [RUN_W-1:0] zr_cur;
  logic [RUN_W-1:0] zr_next;
  logic [SEG_W-1:0] seg_next;
  logic [LEN_W-1:0] len_next;
  logic [1:0]       nz_next;

  logic signed [COEF_W-1:0] c_cl;
  logic signed [COEF_W-1:0] p_cl;
  logic signed [COEF_W:0]   diff;
  logic signed [COEF_W:0]   val;
  logic signed [COEF_W:0]   mag_raw;
  logic        [10:0]       absv;
  logic        [3:0]        cat;
  logic        [COEF_W:0]   mag;
  logic [LEN_W+CODE_W-1:0]  ent;
  logic [7:0]               sym;
  logic                     is_zrl;
  logic [LEN_W+CODE_W-1:0]  zrl_ent;

  assign in_stall = ({1'b0, count} + (PTR_W+2)'(a_valid)) >= (PTR_W+2)'(DEPTH);
  assign in_acc   = in_valid && !in_stall;
  assign zr_cur   = a_fwd ? wb_q : rd_q;

  always_comb begin
    c_cl = (a_coef == {1'b1, {(COEF_W-1){1'b0}}}) ? -COEF_W'(2047) : a_coef;
    p_cl = (a_pred == {1'b1, {(COEF_W-1){1'b0}}}) ? -COEF_W'(2047) : a_pred;
    diff = (COEF_W+1)'(c_cl) - (COEF_W+1)'(p_cl);
    zr_next  = zr_cur;
    push     = 1'b0;
    nz_next  = '0;
    sym      = EOB_SYM;
    val      = '0;
    ent      = '0;
    if (a_pos == '0) begin
      if (diff > (COEF_W+1)'(2047)) val = (COEF_W+1)'(2047);
      else if (diff < -(COEF_W+1)'(2047)) val = -(COEF_W+1)'(2047);
      else val = diff;
    end else if (c_cl > COEF_W'(1023)) begin
      val = (COEF_W+1)'(1023);
    end else if (c_cl < -COEF_W'(1023)) begin
      val = -(COEF_W+1)'(1023);
    end else begin
      val = (COEF_W+1)'(c_cl);
    end
    absv    = val[COEF_W] ? 11'(-val) : 11'(val);
    cat     = category(absv);
    mag_raw = val[COEF_W] ? val - 1'b1 : val;
    mag     = mag_raw & (((COEF_W+1)'(1) << cat) - 1'b1);
    if (a_pos <= LAST_POS) begin
      if (a_pos == '0) begin
        ent     = table_select ? DC_ROM_C[cat] : DC_ROM_L[cat];
        push    = 1'b1;
        zr_next = '0;
      end else if (a_coef == '0) begin
        if (zr_cur != RUN_MAX) zr_next = zr_cur + 1'b1;
        if (a_pos == LAST_POS) begin
          mag     = '0;
          ent     = table_select ? AC_ROM_C[EOB_SYM] : AC_ROM_L[EOB_SYM];
          push    = 1'b1;
          zr_next = '0;
        end
      end else begin
        nz_next = zr_cur[5:4];
        sym     = {zr_cur[3:0], cat};
        ent     = table_select ? AC_ROM_C[sym] : AC_ROM_L[sym];
        push    = 1'b1;
        zr_next = '0;
      end
    end
    push     = push && a_valid;
    seg_next = (SEG_W'(ent[CODE_W-1:0]) << cat) | SEG_W'(mag);
    len_next = ent[LEN_W+CODE_W-1:CODE_W] + LEN_W'(cat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_select <= 1'b0;
    end else if (cfg_write) begin
      table_select <= cfg_data;
    end
  end

  // run count memory with write-back forwarding
  always_ff @(posedge clk) begin
    if (a_valid) begin
      zr_mem[0] <= zr_next;
      wb_q      <= zr_next;
    end
    if (in_acc) begin
      rd_q <= mem_ok ? zr_mem[0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_ok  <= 1'b0;
      a_valid <= 1'b0;
      a_fwd   <= 1'b0;
    end else begin
      if (a_valid) mem_ok <= 1'b1;
      a_valid <= in_acc;
      if (in_acc) a_fwd <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_coef <= coefficient;
      a_pos  <= position;
      a_pred <= dc_predictor;
    end
  end

  // output queue, one entry per item that emits a segment, with its zrl count
  assign zrl_ent        = ent_tsel[rptr] ? AC_ROM_C[ZRL_SYM] : AC_ROM_L[ZRL_SYM];
  assign is_zrl         = zrl_idx != ent_nz[rptr];
  assign out_valid      = count != '0;
  assign segment_value  = is_zrl ? SEG_W'(zrl_ent[CODE_W-1:0]) : ent_seg[rptr];
  assign segment_length = is_zrl ? zrl_ent[LEN_W+CODE_W-1:CODE_W] : ent_len[rptr];
  assign last_of_run    = !is_zrl;
  assign out_acc        = out_valid && !out_stall;
  assign pop            = out_acc && !is_zrl;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_seg[wptr]  <= seg_next;
      ent_len[wptr]  <= len_next;
      ent_nz[wptr]   <= nz_next;
      ent_tsel[wptr] <= table_select;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      rptr    <= '0;
      count   <= '0;
      zrl_idx <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      if (out_acc) zrl_idx <= is_zrl ? zrl_idx + 1'b1 : 2'd0;
    end
  end

endmodule
`default_nettype wire

FILE: design/jbee_checker.sv
// port-level checker for the block entropy encoder, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module jbee_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               cfg_write,
  input wire logic                               cfg_data,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic signed [jbee_pkg::COEF_W-1:0] coefficient,
  input wire logic        [jbee_pkg::POS_W-1:0]  position,
  input wire logic signed [jbee_pkg::COEF_W-1:0] dc_predictor,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic        [jbee_pkg::SEG_W-1:0]  segment_value,
  input wire logic        [jbee_pkg::LEN_W-1:0]  segment_length,
  input wire logic                               last_of_run
);
  import jbee_pkg::*;

  logic unused;
  assign unused = ^{cfg_write, cfg_data, in_valid, in_stall, coefficient, position,
                    dc_predictor, last_of_run};

  `CHECK_PROP(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(segment_value) && $stable(segment_length), "stalled item changed")
  `CHECK_PROP(a_len_range, clk, rst, out_valid |-> segment_length != '0 && segment_length <= LEN_W'(SEG_W), "segment length out of range")
  `CHECK_PROP(a_val_fits, clk, rst, out_valid |-> (segment_value >> segment_length) == '0, "segment bits above length")
  `CHECK_PROP_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind jpeg_block_entropy_encoder jbee_checker u_jbee_checker (.*);
`default_nettype wire
